>>> rtl/core/pcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// shared types, constants and helpers of the packet checksum framer
// ----------------------------------------------------------------------------
package pcf_pkg;

	localparam int MAX_PACKET = 256;
	localparam int CAP = (MAX_PACKET - 1 > 255) ? 255 : (MAX_PACKET - 1);

	localparam logic [7:0] ERR_TYPE  = 8'h1c;
	localparam logic [7:0] ERR_BIZ   = 8'h11;
	localparam logic [7:0] STAR      = 8'h2a;
	localparam logic [7:0] MIN_LEN   = 8'd4;
	localparam logic [8:0] ERR_EXTRA = 9'd6;
	localparam logic [8:0] CAP_W     = 9'(CAP);

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	// command kinds
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_MALF  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HDR_K = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HDR_E = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BODY  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

	// word index within one command, error header is the longest at eight
	localparam int IDX_W = 3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        data;   // type byte for headers, else the body byte or ERR_BIZ
		logic [7:0]        seq;
		logic [7:0]        total;  // length field as it goes out
		logic              err;    // packet is wrapped as an error report
	} cmd_t;

	function automatic logic type_known(input logic [7:0] t);
		return t == 8'h1f || t == 8'h10 || t == 8'h11 || t == 8'h12 ||
		       t == 8'h14 || t == 8'h17 || t == 8'hff;
	endfunction

endpackage

>>> rtl/core/pcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front
// takes raw packet bytes, tracks the header, makes commands from byte 2 on
// ----------------------------------------------------------------------------
module pcf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     in_byte,
	output logic           cmd_push,
	output pcf_pkg::cmd_t  cmd
);

	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] seq_q;
	logic [7:0] type_q;
	logic       err_q;
	logic       drop_q;

	logic [8:0] total;
	logic       at_end;

	assign total  = err_q ? ({1'b0, in_byte} + pcf_pkg::ERR_EXTRA) : {1'b0, in_byte};
	assign at_end = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

	always_comb begin
		cmd_push   = 1'b0;
		cmd.kind   = pcf_pkg::KIND_BODY;
		cmd.data   = in_byte;
		cmd.seq    = seq_q;
		cmd.total  = total[7:0];
		cmd.err    = err_q;
		if (accept && !drop_q && pos_q == 8'd2) begin
			cmd_push = 1'b1;
			cmd.data = type_q;
			if (in_byte < pcf_pkg::MIN_LEN || total > pcf_pkg::CAP_W) begin
				cmd.kind = pcf_pkg::KIND_MALF;
			end else begin
				cmd.kind = err_q ? pcf_pkg::KIND_HDR_E : pcf_pkg::KIND_HDR_K;
			end
		end else if (accept && !drop_q && pos_q > 8'd2) begin
			cmd_push = 1'b1;
			if (at_end) begin
				cmd.kind = pcf_pkg::KIND_END;
			end else if (err_q && pos_q == 8'd3) begin
				cmd.data = pcf_pkg::ERR_BIZ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			seq_q  <= '0;
			type_q <= '0;
			err_q  <= 1'b0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (drop_q) begin
				if (at_end) begin
					pos_q  <= '0;
					drop_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 8'd1;
				end
			end else if (pos_q == 8'd0) begin
				err_q  <= !pcf_pkg::type_known(in_byte);
				type_q <= in_byte;
				pos_q  <= 8'd1;
			end else if (pos_q == 8'd1) begin
				seq_q <= in_byte;
				pos_q <= 8'd2;
			end else if (pos_q == 8'd2) begin
				len_q <= in_byte;
				if (in_byte < pcf_pkg::MIN_LEN) begin
					pos_q <= '0;
				end else begin
					// too long: swallow the rest of the packet
					drop_q <= total > pcf_pkg::CAP_W;
					pos_q  <= 8'd3;
				end
			end else if (at_end) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

>>> rtl/core/pcf_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_cmd_queue
// small register queue of commands between front and back
// ----------------------------------------------------------------------------
module pcf_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pcf_pkg::cmd_t  wr_cmd,
	input  logic           rd_en,
	output pcf_pkg::cmd_t  rd_cmd,
	output logic           q_full,
	output logic           q_empty
);

	pcf_pkg::cmd_t                mem_q [pcf_pkg::CMDQ_DEPTH];
	logic [pcf_pkg::CMDQ_AW-1:0]  wr_ptr_q;
	logic [pcf_pkg::CMDQ_AW-1:0]  rd_ptr_q;
	logic [pcf_pkg::CMDQ_CW-1:0]  count_q;

	assign q_full  = count_q == pcf_pkg::CMDQ_CW'(pcf_pkg::CMDQ_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/pcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_back
// expands commands into framed words and keeps the running checksum
// ----------------------------------------------------------------------------
module pcf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pcf_pkg::cmd_t  head,
	input  logic           head_v,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           wrapped,
	output logic           malformed
);

	logic [pcf_pkg::IDX_W-1:0] idx_q;
	logic [pcf_pkg::IDX_W-1:0] last_idx;
	logic [7:0]                sum_q;
	logic [7:0]                sum_base;
	logic [7:0]                word;
	logic                      word_last;
	logic                      word_bad;
	logic                      out_free;
	logic                      load;

	logic                      out_v_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      wrap_q;
	logic                      bad_q;

	assign out_free = !out_v_q || pop;
	assign load     = head_v && out_free;
	assign head_pop = load && idx_q == last_idx;

	always_comb begin
		last_idx  = '0;
		word      = head.data;
		word_last = 1'b0;
		word_bad  = 1'b0;
		sum_base  = sum_q;
		case (head.kind)
			pcf_pkg::KIND_MALF: begin
				word     = 8'h00;
				word_bad = 1'b1;
			end
			pcf_pkg::KIND_HDR_K: begin
				last_idx = pcf_pkg::IDX_W'(2);
				if (idx_q == pcf_pkg::IDX_W'(0)) sum_base = 8'h00;
				case (idx_q)
					pcf_pkg::IDX_W'(0): word = head.data;
					pcf_pkg::IDX_W'(1): word = head.seq;
					default:            word = head.total;
				endcase
			end
			pcf_pkg::KIND_HDR_E: begin
				last_idx = pcf_pkg::IDX_W'(7);
				if (idx_q == pcf_pkg::IDX_W'(0)) sum_base = 8'h00;
				case (idx_q)
					pcf_pkg::IDX_W'(0): word = pcf_pkg::ERR_TYPE;
					pcf_pkg::IDX_W'(1): word = head.seq;
					pcf_pkg::IDX_W'(2): word = head.total;
					pcf_pkg::IDX_W'(3): word = pcf_pkg::ERR_BIZ;
					pcf_pkg::IDX_W'(4): word = pcf_pkg::STAR;
					pcf_pkg::IDX_W'(5): word = pcf_pkg::ERR_TYPE;
					pcf_pkg::IDX_W'(6): word = head.seq;
					default:            word = pcf_pkg::STAR;
				endcase
			end
			pcf_pkg::KIND_END: begin
				// error reports close with a star ahead of the checksum
				last_idx = head.err ? pcf_pkg::IDX_W'(1) : pcf_pkg::IDX_W'(0);
				if (head.err && idx_q == pcf_pkg::IDX_W'(0)) begin
					word = pcf_pkg::STAR;
				end else begin
					word      = sum_q;
					word_last = 1'b1;
				end
			end
			default: begin
				word = head.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= head_pop ? '0 : idx_q + 1'b1;
				if (!word_last && !word_bad) begin
					sum_q <= sum_base + word;
				end
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= word;
			last_q <= word_last;
			wrap_q <= head.err;
			bad_q  <= word_bad;
		end
	end

	assign empty     = !out_v_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign wrapped   = wrap_q;
	assign malformed = bad_q;

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_v |-> idx_q == '0)
		else $error("word index moved without a command");

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_v && out_free)
		else $error("command retired without being worked");

	a_last_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && last_q |-> !bad_q)
		else $error("malformed word marked as last");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_v |-> idx_q <= last_idx)
		else $error("word index past end of command");

endmodule

>>> rtl/core/packet_checksum_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_checksum_framer_top
// frames outgoing packets and appends or wraps them with an additive checksum
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue write port: in_byte is taken at a clock edge with
//   push high and full low, one raw packet byte per word, type first.
//   output side is a queue read port: while empty is low the oldest framed
//   word sits on out_byte/out_last/wrapped/malformed; pop takes it.
//   header bytes 0 and 1 produce nothing; byte 2 produces the header words
//   (three for a known type, eight for an error report, or one malformed
//   word); each body byte produces one word; the final byte produces the
//   checksum word (preceded by a star for error reports).
//   the command for a byte is written into the command queue as the byte is
//   taken; its words then move from the queue head into the output register.
//   throughput: one input word per cycle while the command queue has room,
//   one output word per cycle from the expansion unit while pop frees the
//   output register; the headers and the error close are bursts, soaked up
//   by the four-entry command queue. a stalled reader fills the output
//   register, then the command queue, then raises full; nothing is lost.
//   reset clears the parser, the queue and the output register; the first
//   word after reset is taken as a packet type.
// ----------------------------------------------------------------------------
module packet_checksum_framer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       wrapped,
	output logic       malformed
);

	// input handshake
	logic          accept;

	// front to queue
	logic          cmd_push;
	pcf_pkg::cmd_t cmd;

	// queue to back
	pcf_pkg::cmd_t head;
	logic          head_pop;
	logic          q_empty;

	assign accept = push && !full;

	// parser: header tracking, length checks, drop of oversized packets
	pcf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	// decoupling queue, its fill sets full
	pcf_cmd_queue u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_cmd  (cmd),
		.rd_en   (head_pop),
		.rd_cmd  (head),
		.q_full  (full),
		.q_empty (q_empty)
	);

	// word expansion, checksum and output register
	pcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_v    (!q_empty),
		.head_pop  (head_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.wrapped   (wrapped),
		.malformed (malformed)
	);

endmodule
